// ===== rtl/bwbs_pkg.sv =====
// Shared types, constants and register indexes for the white-balance statistics block.
package bwbs_pkg;

    // Default parameter values
    localparam int DEF_PIXEL_BITS = 12;
    localparam int DEF_SUM_BITS   = 33;

    // Fixed field widths
    localparam int CNT_BITS        = 13;
    localparam int COEFF_BITS      = 16;
    localparam int GAIN_BITS       = 23;
    localparam int GREEN_GAIN_BITS = 13;

    // Scaling shifts and ratio constants
    localparam int SHIFT_RB    = 19;
    localparam int SHIFT_G     = 20;
    localparam int RATIO_SHIFT = 11;
    localparam logic [GREEN_GAIN_BITS-1:0] RATIO_GREEN = 13'd4096;

    // Configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BAYER_PHASE  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STATS_ENABLE = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_AVG_COEFF    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RATIO_MODE   = 3'd5;

    // Register reset values
    localparam logic [CNT_BITS-1:0]   RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [CNT_BITS-1:0]   RST_FRAME_HEIGHT = 13'd1080;
    localparam logic [1:0]            RST_BAYER_PHASE  = 2'd0;
    localparam logic                  RST_STATS_ENABLE = 1'b1;
    localparam logic [COEFF_BITS-1:0] RST_AVG_COEFF    = 16'd1;
    localparam logic                  RST_RATIO_MODE   = 1'b0;

    // Colour channel codes after the phase XOR
    localparam logic [1:0] CH_RED  = 2'd0;
    localparam logic [1:0] CH_BLUE = 2'd3;

    // Sequence positions of the gain unit channels
    localparam logic [1:0] SEQ_RED   = 2'd0;
    localparam logic [1:0] SEQ_GREEN = 2'd1;
    localparam logic [1:0] SEQ_BLUE  = 2'd2;

    // Gain sequencer states
    typedef enum logic [1:0] {
        GS_IDLE,
        GS_MUL,
        GS_DIV,
        GS_DONE
    } t_gain_state;

    // Request from the stream side to the gain sequencer
    typedef struct packed {
        logic start;
        logic ratio_mode;
    } t_gain_req;

endpackage

// ===== rtl/bayer_white_balance_stats_core.sv =====
// Top level: pixel pass-through, Bayer channel sums and frame-end gain update.
//
//  Channel  | Direction | Word contents
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tdata: pixel_in
//  m_axis   | out       | tdata: pixel_out, red_gain, green_gain, blue_gain;
//           |           | tlast: frame_done
//  cfg      | in        | i_cfg_addr register index, i_cfg_data value
//
// Each ordinary pixel goes to the output register as it is accepted; the next can follow
// while that register is free or draining. The last pixel of a frame first starts the
// gain unit: shift-add multiplies, then ratio-mode restoring division, on one shared adder.
// s_axis_tready stays low from that pixel until its word is loaded into the output register.
// Reset (synchronous, active low) clears counters, sums, held gains; resets registers.
// Output stalls hold the output register; input is taken only when it is free or draining.
module bayer_white_balance_stats_core #(
    parameter int PIXEL_BITS = bwbs_pkg::DEF_PIXEL_BITS,
    parameter int SUM_BITS   = bwbs_pkg::DEF_SUM_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // pixel_in
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // pixel_out, red_gain, green_gain, blue_gain
    output logic [((PIXEL_BITS+59+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                    m_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [bwbs_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [bwbs_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);
    import bwbs_pkg::*;

    // Configuration registers
    logic [CNT_BITS-1:0]   r_frame_width;
    logic [CNT_BITS-1:0]   r_frame_height;
    logic [1:0]            r_bayer_phase;
    logic                  r_stats_enable;
    logic [COEFF_BITS-1:0] r_avg_coeff;
    logic                  r_ratio_mode;

    // Frame position and sums
    logic [CNT_BITS-1:0]   r_col, n_col;
    logic [CNT_BITS-1:0]   r_row, n_row;
    logic [SUM_BITS-1:0]   r_sum_r, n_sum_r;
    logic [SUM_BITS-1:0]   r_sum_g, n_sum_g;
    logic [SUM_BITS-1:0]   r_sum_b, n_sum_b;

    // Held gains and control
    logic [GAIN_BITS-1:0]       r_gain_r;
    logic [GREEN_GAIN_BITS-1:0] r_gain_g;
    logic [GAIN_BITS-1:0]       r_gain_b;
    logic                       r_busy;
    logic                       r_gains_ok;
    logic                       r_start;
    logic [PIXEL_BITS-1:0]      r_pix_hold;

    // Output register
    logic                       r_out_valid;
    logic                       r_out_last;
    logic [PIXEL_BITS-1:0]      r_out_pix;
    logic [GAIN_BITS-1:0]       r_out_gain_r;
    logic [GREEN_GAIN_BITS-1:0] r_out_gain_g;
    logic [GAIN_BITS-1:0]       r_out_gain_b;

    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_emit_end;
    logic [PIXEL_BITS-1:0]      w_pix;
    logic [1:0]                 w_chan;
    logic                       w_row_end;
    logic                       w_frame_end;
    logic                       w_done;
    logic [GAIN_BITS-1:0]       w_gain_r;
    logic [GREEN_GAIN_BITS-1:0] w_gain_g;
    logic [GAIN_BITS-1:0]       w_gain_b;
    t_gain_req                  w_req;

    // Handshakes
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_busy && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_emit_end    = r_busy && r_gains_ok && w_out_free;
    assign w_pix         = s_axis_tdata[PIXEL_BITS-1:0];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_bayer_phase  <= RST_BAYER_PHASE;
            r_stats_enable <= RST_STATS_ENABLE;
            r_avg_coeff    <= RST_AVG_COEFF;
            r_ratio_mode   <= RST_RATIO_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CNT_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CNT_BITS-1:0];
                CFG_BAYER_PHASE:  r_bayer_phase  <= i_cfg_data[1:0];
                CFG_STATS_ENABLE: r_stats_enable <= i_cfg_data[0];
                CFG_AVG_COEFF:    r_avg_coeff    <= i_cfg_data[COEFF_BITS-1:0];
                CFG_RATIO_MODE:   r_ratio_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Position counters and channel accumulation for the accepted pixel
    always_comb begin
        w_chan      = {r_row[0], r_col[0]} ^ r_bayer_phase;
        w_row_end   = ({1'b0, r_col} + 14'd1) >= {1'b0, r_frame_width};
        w_frame_end = w_row_end && (({1'b0, r_row} + 14'd1) >= {1'b0, r_frame_height});
        n_col   = r_col;
        n_row   = r_row;
        n_sum_r = r_sum_r;
        n_sum_g = r_sum_g;
        n_sum_b = r_sum_b;
        if (w_accept) begin
            if (r_stats_enable) begin
                case (w_chan)
                    CH_RED:  n_sum_r = r_sum_r + SUM_BITS'(w_pix);
                    CH_BLUE: n_sum_b = r_sum_b + SUM_BITS'(w_pix);
                    default: n_sum_g = r_sum_g + SUM_BITS'(w_pix);
                endcase
            end
            if (w_row_end) begin
                n_col = '0;
                n_row = w_frame_end ? '0 : r_row + CNT_BITS'(1);
            end else begin
                n_col = r_col + CNT_BITS'(1);
            end
        end
        // Clear the sums once the gain unit has read them
        if (w_done) begin
            n_sum_r = '0;
            n_sum_g = '0;
            n_sum_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_sum_r <= n_sum_r;
            r_sum_g <= n_sum_g;
            r_sum_b <= n_sum_b;
        end
    end

    // Frame-end gain computation
    assign w_req.start      = r_start;
    assign w_req.ratio_mode = r_ratio_mode;

    bwbs_gain_seq #(
        .PIXEL_BITS (PIXEL_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_gain_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_req),
        .i_coeff      (r_avg_coeff),
        .i_red_sum    (r_sum_r),
        .i_green_sum  (r_sum_g),
        .i_blue_sum   (r_sum_b),
        .o_done       (w_done),
        .o_red_gain   (w_gain_r),
        .o_green_gain (w_gain_g),
        .o_blue_gain  (w_gain_b)
    );

    // Track the frame-end word and latch new gains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_gains_ok <= 1'b0;
            r_start    <= 1'b0;
            r_gain_r   <= '0;
            r_gain_g   <= '0;
            r_gain_b   <= '0;
        end else begin
            r_start <= w_accept && w_frame_end;
            if (w_accept && w_frame_end) begin
                r_busy <= 1'b1;
            end else if (w_emit_end) begin
                r_busy     <= 1'b0;
                r_gains_ok <= 1'b0;
            end
            if (w_done) begin
                r_gains_ok <= 1'b1;
                r_gain_r   <= w_gain_r;
                r_gain_g   <= w_gain_g;
                r_gain_b   <= w_gain_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix_hold <= w_pix;
        end
    end

    // Output register: load plain pixels at once, the frame-end word once gains are ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && !w_frame_end) begin
            r_out_valid <= 1'b1;
        end else if (w_emit_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_frame_end) begin
            r_out_last   <= 1'b0;
            r_out_pix    <= w_pix;
            r_out_gain_r <= r_gain_r;
            r_out_gain_g <= r_gain_g;
            r_out_gain_b <= r_gain_b;
        end else if (w_emit_end) begin
            r_out_last   <= 1'b1;
            r_out_pix    <= r_pix_hold;
            r_out_gain_r <= r_gain_r;
            r_out_gain_g <= r_gain_g;
            r_out_gain_b <= r_gain_b;
        end
    end

    // Pack the output word
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[PIXEL_BITS-1:0]                       = r_out_pix;
        m_axis_tdata[PIXEL_BITS +: GAIN_BITS]              = r_out_gain_r;
        m_axis_tdata[PIXEL_BITS+GAIN_BITS +: GREEN_GAIN_BITS] = r_out_gain_g;
        m_axis_tdata[PIXEL_BITS+GAIN_BITS+GREEN_GAIN_BITS +: GAIN_BITS] = r_out_gain_b;
    end
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;

    // No input taken while a frame-end word is outstanding
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready)
        else $error("input accepted during gain computation");

    // Gain unit finishes only for an outstanding frame end
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_busy && !r_gains_ok))
        else $error("gain unit finished without a pending frame end");

    // A frame-end pixel starts the gain unit on the next cycle
    a_frame_end_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_frame_end) |=> (r_busy && r_start))
        else $error("frame end did not start the gain unit");

    // Sums are cleared by the time the frame-end word leaves the busy phase
    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_sum_r == '0 && r_sum_g == '0 && r_sum_b == '0
                           && r_out_last && r_out_valid))
        else $error("sums not cleared after frame end");

endmodule

// ===== rtl/bwbs_addsub.sv =====
// Shared adder/subtractor used by the gain sequencer for both multiply and divide steps.
module bwbs_addsub #(
    parameter int WIDTH = 49
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_y
);

    // Add, or subtract through the inverted operand and carry in
    assign o_y = i_a + (i_sub ? ~i_b : i_b) + {{(WIDTH-1){1'b0}}, i_sub};

endmodule

// ===== rtl/bwbs_gain_seq.sv =====
// Sequencer that scales the channel sums and forms the gains with one shared adder.
module bwbs_gain_seq #(
    parameter int PIXEL_BITS = bwbs_pkg::DEF_PIXEL_BITS,
    parameter int SUM_BITS   = bwbs_pkg::DEF_SUM_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bwbs_pkg::t_gain_req                    i_req,
    input  logic [bwbs_pkg::COEFF_BITS-1:0]        i_coeff,
    input  logic [SUM_BITS-1:0]                    i_red_sum,
    input  logic [SUM_BITS-1:0]                    i_green_sum,
    input  logic [SUM_BITS-1:0]                    i_blue_sum,
    output logic                                   o_done,
    output logic [bwbs_pkg::GAIN_BITS-1:0]         o_red_gain,
    output logic [bwbs_pkg::GREEN_GAIN_BITS-1:0]   o_green_gain,
    output logic [bwbs_pkg::GAIN_BITS-1:0]         o_blue_gain
);
    import bwbs_pkg::*;

    localparam int PW    = SUM_BITS + COEFF_BITS;
    localparam int MB    = $clog2(COEFF_BITS);
    localparam int DB    = $clog2(PIXEL_BITS);
    localparam int STEPW = (MB > DB) ? MB : DB;

    t_gain_state r_state, n_state;
    logic [1:0]            r_chan, n_chan;
    logic [STEPW-1:0]      r_step, n_step;
    logic                  r_ratio, n_ratio;
    logic [PW-1:0]         r_acc, n_acc;
    logic [PIXEL_BITS-1:0] r_avg_r, n_avg_r;
    logic [PIXEL_BITS-1:0] r_avg_g, n_avg_g;
    logic [PIXEL_BITS-1:0] r_avg_b, n_avg_b;
    logic [PIXEL_BITS-1:0] r_rem, n_rem;
    logic [PIXEL_BITS-1:0] r_quo, n_quo;
    logic [PIXEL_BITS-1:0] r_quo_r, n_quo_r;
    logic [PIXEL_BITS-1:0] r_quo_b, n_quo_b;

    logic [PW-1:0]         w_a, w_b, w_y;
    logic                  w_sub;
    logic [SUM_BITS-1:0]   w_sum_sel;
    logic [PIXEL_BITS:0]   w_trial;
    logic [PIXEL_BITS-1:0] w_den;
    logic [PIXEL_BITS-1:0] w_avg_new;
    logic [PIXEL_BITS-1:0] w_quo_new;
    logic                  w_ge;

    // Shared arithmetic unit
    bwbs_addsub #(.WIDTH(PW)) u_addsub (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_sub),
        .o_y   (w_y)
    );

    // Operand selection for the current step
    always_comb begin
        case (r_chan)
            SEQ_RED:   w_sum_sel = i_red_sum;
            SEQ_GREEN: w_sum_sel = i_green_sum;
            default:   w_sum_sel = i_blue_sum;
        endcase
        w_den     = r_chan[1] ? r_avg_b : r_avg_r;
        w_trial   = {r_rem, r_avg_g[r_step[DB-1:0]]};
        if (r_state == GS_DIV) begin
            w_a   = PW'(w_trial);
            w_b   = PW'(w_den);
            w_sub = 1'b1;
        end else begin
            w_a   = {r_acc[PW-2:0], 1'b0};
            w_b   = i_coeff[r_step[MB-1:0]] ? PW'(w_sum_sel) : '0;
            w_sub = 1'b0;
        end
    end

    // Trial result, next quotient and scaled average from the adder output
    assign w_ge      = ~w_y[PW-1];
    assign w_quo_new = {r_quo[PIXEL_BITS-2:0], w_ge};
    assign w_avg_new = (r_chan == SEQ_GREEN) ? w_y[SHIFT_G +: PIXEL_BITS]
                                             : w_y[SHIFT_RB +: PIXEL_BITS];

    // Next state: multiply each sum bit-serially, then in ratio mode divide green by red and blue
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        n_step  = r_step;
        n_ratio = r_ratio;
        n_acc   = r_acc;
        n_avg_r = r_avg_r;
        n_avg_g = r_avg_g;
        n_avg_b = r_avg_b;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_quo_r = r_quo_r;
        n_quo_b = r_quo_b;
        o_done  = 1'b0;
        case (r_state)
            GS_IDLE: begin
                if (i_req.start) begin
                    n_state = GS_MUL;
                    n_ratio = i_req.ratio_mode;
                    n_chan  = SEQ_RED;
                    n_step  = STEPW'(COEFF_BITS - 1);
                    n_acc   = '0;
                end
            end
            GS_MUL: begin
                n_acc = w_y;
                if (r_step == '0) begin
                    case (r_chan)
                        SEQ_RED:   n_avg_r = w_avg_new;
                        SEQ_GREEN: n_avg_g = w_avg_new;
                        default:   n_avg_b = w_avg_new;
                    endcase
                    n_acc  = '0;
                    n_step = STEPW'(COEFF_BITS - 1);
                    if (r_chan == SEQ_BLUE) begin
                        if (r_ratio) begin
                            n_state = GS_DIV;
                            n_chan  = SEQ_RED;
                            n_step  = STEPW'(PIXEL_BITS - 1);
                            n_rem   = '0;
                            n_quo   = '0;
                        end else begin
                            n_state = GS_DONE;
                        end
                    end else begin
                        n_chan = r_chan + 2'd1;
                    end
                end else begin
                    n_step = r_step - STEPW'(1);
                end
            end
            GS_DIV: begin
                // Restoring step; a zero divisor always passes, giving all ones
                n_rem = w_ge ? w_y[PIXEL_BITS-1:0] : w_trial[PIXEL_BITS-1:0];
                n_quo = w_quo_new;
                if (r_step == '0) begin
                    n_rem = '0;
                    n_quo = '0;
                    if (r_chan == SEQ_BLUE) begin
                        n_quo_b = w_quo_new;
                        n_state = GS_DONE;
                    end else begin
                        n_quo_r = w_quo_new;
                        n_chan  = SEQ_BLUE;
                        n_step  = STEPW'(PIXEL_BITS - 1);
                    end
                end else begin
                    n_step = r_step - STEPW'(1);
                end
            end
            GS_DONE: begin
                o_done  = 1'b1;
                n_state = GS_IDLE;
            end
            default: n_state = GS_IDLE;
        endcase
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_chan  <= n_chan;
        r_step  <= n_step;
        r_ratio <= n_ratio;
        r_acc   <= n_acc;
        r_avg_r <= n_avg_r;
        r_avg_g <= n_avg_g;
        r_avg_b <= n_avg_b;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_quo_r <= n_quo_r;
        r_quo_b <= n_quo_b;
    end

    // Gains for the selected mode
    assign o_red_gain   = r_ratio ? GAIN_BITS'({r_quo_r, {RATIO_SHIFT{1'b0}}})
                                  : GAIN_BITS'(r_avg_r);
    assign o_green_gain = r_ratio ? RATIO_GREEN : GREEN_GAIN_BITS'(r_avg_g);
    assign o_blue_gain  = r_ratio ? GAIN_BITS'({r_quo_b, {RATIO_SHIFT{1'b0}}})
                                  : GAIN_BITS'(r_avg_b);

endmodule

// ===== tb/bayer_white_balance_stats_core_tb.sv =====
// Self-checking testbench for the Bayer white-balance statistics core.
module bayer_white_balance_stats_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bwbs_pkg::*;

    localparam int PIX_W     = DEF_PIXEL_BITS;
    localparam int SUM_W     = DEF_SUM_BITS;
    localparam int S_DATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((PIX_W + 59 + 7) / 8) * 8;
    localparam int MAX_STALL = 18;
    localparam int RANDOM_PIXELS = 1080;
    localparam int REPORT_LIMIT  = 10;

    // One output word split into its fields
    typedef struct packed {
        logic [PIX_W-1:0]           pixel;
        logic                       frame_done;
        logic [GAIN_BITS-1:0]       red_gain;
        logic [GREEN_GAIN_BITS-1:0] green_gain;
        logic [GAIN_BITS-1:0]       blue_gain;
    } t_balance_word;

    logic                         i_clk;
    logic                         i_rst_n;
    logic [S_DATA_W-1:0]          s_axis_tdata;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [M_DATA_W-1:0]          m_axis_tdata;
    logic                         m_axis_tlast;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [CFG_ADDR_BITS-1:0]     i_cfg_addr;
    logic [CFG_DATA_BITS-1:0]     i_cfg_data;

    // Predictor copy of the registers and state
    logic [CNT_BITS-1:0]    model_width;
    logic [CNT_BITS-1:0]    model_height;
    logic [1:0]             model_phase;
    logic                   model_enable;
    logic [COEFF_BITS-1:0]  model_coeff;
    logic                   model_ratio;
    logic [SUM_W-1:0]       red_total;
    logic [SUM_W-1:0]       green_total;
    logic [SUM_W-1:0]       blue_total;
    logic [CNT_BITS-1:0]    col_pos;
    logic [CNT_BITS-1:0]    row_pos;
    logic [GAIN_BITS-1:0]   red_held;
    logic [GREEN_GAIN_BITS-1:0] green_held;
    logic [GAIN_BITS-1:0]   blue_held;

    t_balance_word balance_words_due[$];
    int mismatch_count;
    int tx_max_gap;
    int rx_max_stall;
    int rx_hold;
    int rx_draw;

    bayer_white_balance_stats_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Scale a channel sum into a 12-bit average
    function automatic logic [PIX_W-1:0] scale_sum(input logic [SUM_W-1:0] total, input int sh);
        logic [63:0] product;
        product = 64'(total) * 64'(model_coeff);
        return PIX_W'(product >> sh);
    endfunction

    // Green-over-channel quotient in 2048ths, saturated on a zero divisor
    function automatic logic [GAIN_BITS-1:0] ratio_to_gain(input logic [PIX_W-1:0] num,
                                                            input logic [PIX_W-1:0] den);
        logic [PIX_W-1:0] quot;
        quot = (den == '0) ? {PIX_W{1'b1}} : PIX_W'(num / den);
        return GAIN_BITS'({quot, 11'b0});
    endfunction

    // Advance the position and sums by one pixel and form the word it produces
    function automatic t_balance_word predict_balance_word(input logic [PIX_W-1:0] pix);
        t_balance_word word;
        logic [1:0] chan;
        logic frame_end;
        logic [PIX_W-1:0] red_avg;
        logic [PIX_W-1:0] green_avg;
        logic [PIX_W-1:0] blue_avg;
        frame_end = 1'b0;
        chan = {row_pos[0], col_pos[0]} ^ model_phase;
        if (model_enable) begin
            if (chan == CH_RED) red_total = red_total + SUM_W'(pix);
            else if (chan == CH_BLUE) blue_total = blue_total + SUM_W'(pix);
            else green_total = green_total + SUM_W'(pix);
        end
        // A zero size or a counter past the limit both count as the last position
        if (int'(col_pos) + 1 >= int'(model_width)) begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= int'(model_height)) begin
                row_pos = '0;
                frame_end = 1'b1;
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
        if (frame_end) begin
            red_avg   = scale_sum(red_total, SHIFT_RB);
            green_avg = scale_sum(green_total, SHIFT_G);
            blue_avg  = scale_sum(blue_total, SHIFT_RB);
            if (model_ratio) begin
                red_held   = ratio_to_gain(green_avg, red_avg);
                green_held = RATIO_GREEN;
                blue_held  = ratio_to_gain(green_avg, blue_avg);
            end else begin
                red_held   = GAIN_BITS'(red_avg);
                green_held = GREEN_GAIN_BITS'(green_avg);
                blue_held  = GAIN_BITS'(blue_avg);
            end
            red_total   = '0;
            green_total = '0;
            blue_total  = '0;
        end
        word.pixel      = pix;
        word.frame_done = frame_end;
        word.red_gain   = red_held;
        word.green_gain = green_held;
        word.blue_gain  = blue_held;
        return word;
    endfunction

    // Present one pixel after a random gap, record its word, wait for acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'(pix);
        balance_words_due.push_back(predict_balance_word(pix));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Write one register; the next pixel drops the valid
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        case (addr)
            CFG_FRAME_WIDTH:  model_width  = value[CNT_BITS-1:0];
            CFG_FRAME_HEIGHT: model_height = value[CNT_BITS-1:0];
            CFG_BAYER_PHASE:  model_phase  = value[1:0];
            CFG_STATS_ENABLE: model_enable = value[0];
            CFG_AVG_COEFF:    model_coeff  = value;
            CFG_RATIO_MODE:   model_ratio  = value[0];
            default: ;
        endcase
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Hold the input until every outstanding word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (balance_words_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic setup_frame(input int width, input int height, input int phase,
                               input int enable, input int coeff, input int ratio);
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(width));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(height));
        write_reg(CFG_BAYER_PHASE, CFG_DATA_BITS'(phase));
        write_reg(CFG_STATS_ENABLE, CFG_DATA_BITS'(enable));
        write_reg(CFG_AVG_COEFF, CFG_DATA_BITS'(coeff));
        write_reg(CFG_RATIO_MODE, CFG_DATA_BITS'(ratio));
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {PIX_W{1'b1}};
            default: return PIX_W'($urandom_range(0, (1 << PIX_W) - 1));
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return MAX_STALL;
            default: return $urandom_range(1, MAX_STALL);
        endcase
    endfunction

    // Default registers: gains stay at zero, no frame completes
    task automatic test_reset_defaults();
        send_pixel('0);
        send_pixel({PIX_W{1'b1}});
        send_pixel(12'h555);
        send_pixel(12'hAAA);
        send_pixel(12'h123);
        drain_results();
    endtask

    // Full-scale and zero frames in direct mode, taken up from a stale column
    task automatic test_direct_extremes();
        setup_frame(2, 2, 0, 1, 16'hFFFF, 0);
        repeat (4) send_pixel({PIX_W{1'b1}});
        repeat (4) send_pixel({PIX_W{1'b1}});
        repeat (4) send_pixel('0);
        drain_results();
    endtask

    // Ratio mode, including zero red and blue averages
    task automatic test_ratio_mode();
        setup_frame(2, 2, 0, 1, 16'hFFFF, 1);
        send_pixel('0);
        send_pixel({PIX_W{1'b1}});
        send_pixel({PIX_W{1'b1}});
        send_pixel({PIX_W{1'b1}});
        repeat (4) send_pixel({PIX_W{1'b1}});
        drain_results();
        write_reg(CFG_AVG_COEFF, '0);
        repeat (4) send_pixel(random_pixel());
        drain_results();
    endtask

    // Every phase, statistics off, and zero sizes acting as one
    task automatic test_phases_and_sizes();
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            setup_frame(2, 2, ph, 1, 16'd40000, ph[0]);
            send_pixel(12'd100);
            send_pixel(12'd2000);
            send_pixel(12'd3000);
            send_pixel(12'd4000);
        end
        drain_results();
        write_reg(CFG_STATS_ENABLE, '0);
        repeat (4) send_pixel(random_pixel());
        drain_results();
        setup_frame(0, 0, 3, 1, 16'hFFFF, 0);
        repeat (3) send_pixel(random_pixel());
        drain_results();
    endtask

    // Largest sizes, then shrink so both counters sit past their limits
    task automatic test_counter_overrun();
        write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
        write_reg(CFG_FRAME_HEIGHT, 16'd8191);
        repeat (5) send_pixel(random_pixel());
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        repeat (6) send_pixel(random_pixel());
        drain_results();
        write_reg(CFG_FRAME_WIDTH, 16'd1);
        write_reg(CFG_FRAME_HEIGHT, 16'd8);
        repeat (5) send_pixel(random_pixel());
        drain_results();
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        repeat (4) send_pixel(random_pixel());
        drain_results();
    endtask

    // Random settings, whole frames, odd partial frames and varying back-pressure
    task automatic test_random_frames();
        int sent;
        int width;
        int height;
        int coeff;
        int frames;
        int extra;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            drain_results();
            tx_max_gap   = pick_idle();
            rx_max_stall = pick_idle();
            width  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            height = $urandom_range(1, 6);
            case ($urandom_range(0, 5))
                0: coeff = 0;
                1: coeff = 16'hFFFF;
                default: coeff = $urandom_range(0, 16'hFFFF);
            endcase
            setup_frame(width, height, $urandom_range(0, 3), ($urandom_range(0, 7) != 0),
                        coeff, $urandom_range(0, 1));
            frames = $urandom_range(1, 3);
            // Stop at the pixel budget, even part way through a frame
            repeat (frames * width * height) begin
                if (sent < RANDOM_PIXELS) begin
                    send_pixel(random_pixel());
                    sent++;
                end
            end
            // Leave a frame half done now and then, so the next settings start mid-frame
            if ($urandom_range(0, 3) == 0) begin
                extra = $urandom_range(1, width * height);
                repeat (extra) begin
                    if (sent < RANDOM_PIXELS) begin
                        send_pixel(random_pixel());
                        sent++;
                    end
                end
            end
        end
        drain_results();
    endtask

    // Receiver: after each word, stall for a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            if (rx_hold == 0) m_axis_tready <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = $urandom_range(0, rx_max_stall);
            if (rx_draw > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_draw;
            end
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_balance_word want;
        t_balance_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pixel      = m_axis_tdata[PIX_W-1:0];
            got.frame_done = m_axis_tlast;
            got.red_gain   = m_axis_tdata[PIX_W +: GAIN_BITS];
            got.green_gain = m_axis_tdata[PIX_W + GAIN_BITS +: GREEN_GAIN_BITS];
            got.blue_gain  = m_axis_tdata[PIX_W + GAIN_BITS + GREEN_GAIN_BITS +: GAIN_BITS];
            if (balance_words_due.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: unexpected word pixel=%0d done=%0d", $realtime,
                             got.pixel, got.frame_done);
                mismatch_count++;
            end else begin
                want = balance_words_due.pop_front();
                if (got.pixel !== want.pixel || got.frame_done !== want.frame_done ||
                    got.red_gain !== want.red_gain || got.green_gain !== want.green_gain ||
                    got.blue_gain !== want.blue_gain) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: mismatch exp pix=%0d done=%0d r=%0d g=%0d b=%0d %s",
                                 $realtime, want.pixel, want.frame_done, want.red_gain,
                                 want.green_gain, want.blue_gain,
                                 $sformatf("got pix=%0d done=%0d r=%0d g=%0d b=%0d",
                                           got.pixel, got.frame_done, got.red_gain,
                                           got.green_gain, got.blue_gain));
                    mismatch_count++;
                end
            end
        end
    end

    // Give up after a generous fixed time
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        m_axis_tready <= 1'b1;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        mismatch_count = 0;
        tx_max_gap     = MAX_STALL;
        rx_max_stall   = MAX_STALL;
        model_width  = RST_FRAME_WIDTH;
        model_height = RST_FRAME_HEIGHT;
        model_phase  = RST_BAYER_PHASE;
        model_enable = RST_STATS_ENABLE;
        model_coeff  = RST_AVG_COEFF;
        model_ratio  = RST_RATIO_MODE;
        red_total    = '0;
        green_total  = '0;
        blue_total   = '0;
        col_pos      = '0;
        row_pos      = '0;
        red_held     = '0;
        green_held   = '0;
        blue_held    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_direct_extremes();
        test_ratio_mode();
        test_phases_and_sizes();
        test_counter_overrun();
        test_random_frames();

        // Allow for a late frame-end word before judging
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0 && balance_words_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
